// ===== rtl/rfr_pkg.sv =====
// Package for the rational FIR resampler: constants, state codes and the
// coefficient ROM function. No dependencies.
package rfr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ROM_BITS    = 18;
  localparam int ROM_DEPTH   = 63;

  localparam logic [1:0] UP_MODE0   = 2'd3;
  localparam logic [1:0] DOWN_MODE0 = 2'd2;
  localparam logic [1:0] UP_MODE1   = 2'd2;
  localparam logic [1:0] DOWN_MODE1 = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WRITE = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  // Coefficient ROM, signed Q1.17, taps sum to 2^17.
  function automatic logic signed [ROM_BITS-1:0] coef_rom(input logic [7:0] k);
    logic signed [ROM_BITS-1:0] c;
    case (k)
      8'd0: c = -18'sd14;     8'd1: c = 18'sd81;      8'd2: c = 18'sd127;
      8'd3: c = 18'sd75;      8'd4: c = -18'sd69;     8'd5: c = -18'sd213;
      8'd6: c = -18'sd215;    8'd7: c = 18'sd0;       8'd8: c = 18'sd321;
      8'd9: c = 18'sd473;     8'd10: c = 18'sd225;    8'd11: c = -18'sd351;
      8'd12: c = -18'sd827;   8'd13: c = -18'sd695;   8'd14: c = 18'sd150;
      8'd15: c = 18'sd1165;   8'd16: c = 18'sd1445;   8'd17: c = 18'sd470;
      8'd18: c = -18'sd1278;  8'd19: c = -18'sd2430;  8'd20: c = -18'sd1712;
      8'd21: c = 18'sd845;    8'd22: c = 18'sd3514;   8'd23: c = 18'sd3865;
      8'd24: c = 18'sd691;    8'd25: c = -18'sd4505;  8'd26: c = -18'sd7784;
      8'd27: c = -18'sd5014;  8'd28: c = 18'sd5202;   8'd29: c = 18'sd19932;
      8'd30: c = 18'sd32975;  8'd31: c = 18'sd38174;  8'd32: c = 18'sd32975;
      8'd33: c = 18'sd19932;  8'd34: c = 18'sd5202;   8'd35: c = -18'sd5014;
      8'd36: c = -18'sd7784;  8'd37: c = -18'sd4505;  8'd38: c = 18'sd691;
      8'd39: c = 18'sd3865;   8'd40: c = 18'sd3514;   8'd41: c = 18'sd845;
      8'd42: c = -18'sd1712;  8'd43: c = -18'sd2430;  8'd44: c = -18'sd1278;
      8'd45: c = 18'sd470;    8'd46: c = 18'sd1445;   8'd47: c = 18'sd1165;
      8'd48: c = 18'sd150;    8'd49: c = -18'sd695;   8'd50: c = -18'sd827;
      8'd51: c = -18'sd351;   8'd52: c = 18'sd225;    8'd53: c = 18'sd473;
      8'd54: c = 18'sd321;    8'd55: c = 18'sd0;      8'd56: c = -18'sd215;
      8'd57: c = -18'sd213;   8'd58: c = -18'sd69;    8'd59: c = 18'sd75;
      8'd60: c = 18'sd127;    8'd61: c = 18'sd81;     8'd62: c = -18'sd14;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/rfr_serial_mac.sv =====
// Bit-serial multiply-accumulate: one sample bit per cycle while step_i is high, against a
// parallel coefficient. Depends on rfr_pkg.
module rfr_serial_mac #(
  parameter int COEF_BITS = 18,
  parameter int ACC_BITS  = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        load_i,
  input  logic                        step_i,
  input  logic signed [15:0]          sample_i,
  input  logic signed [COEF_BITS-1:0] coef_i,
  output logic                        done_o,
  output logic signed [ACC_BITS-1:0]  acc_o
);
  import rfr_pkg::*;

  logic [15:0]                 shift_q, shift_d;
  logic [4:0]                  bit_q, bit_d;
  logic                        busy_q, busy_d;
  logic signed [COEF_BITS-1:0] coef_q, coef_d;
  logic signed [ACC_BITS-1:0]  acc_q, acc_d;
  logic signed [ACC_BITS-1:0]  term;

  // Shift-and-add, MSB first; the sign bit carries negative weight.
  always_comb begin
    shift_d = shift_q;
    bit_d   = bit_q;
    busy_d  = busy_q;
    coef_d  = coef_q;
    acc_d   = acc_q;
    term    = ACC_BITS'(coef_q);
    if (clear_i) begin
      acc_d = '0;
    end
    if (load_i) begin
      shift_d = sample_i;
      coef_d  = coef_i;
      bit_d   = 5'd15;
      busy_d  = 1'b1;
    end else if (step_i && busy_q) begin
      if (shift_q[bit_q[3:0]]) begin
        if (bit_q == 5'd15) begin
          acc_d = acc_q - (term <<< bit_q);
        end else begin
          acc_d = acc_q + (term <<< bit_q);
        end
      end
      if (bit_q == 5'd0) begin
        busy_d = 1'b0;
      end else begin
        bit_d = bit_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    coef_q  <= coef_d;
    acc_q   <= acc_d;
  end

  assign done_o = busy_q && step_i && (bit_q == 5'd0);
  assign acc_o  = acc_q;
endmodule

// ===== rtl/rational_fir_resampler.sv =====
// Rational FIR resampler top: delay line RAM, sequencer, serial MAC.
// Depends on rfr_pkg and rfr_serial_mac.
// A slot without an output only writes the delay line; a slot with an output writes it, then runs
// a RAM read, a MAC load and 16 MAC bit steps per tap, then rounds and delivers the result.
// stall_o holds off the next input until every slot of the current input is done.
// Reset clears the delay line before the first input is accepted.
module rational_fir_resampler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] sample_in_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] sample_out_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import rfr_pkg::*;

  localparam int NUM_TAPS  = ROM_DEPTH;
  localparam int COEF_BITS = ROM_BITS;
  localparam int AW   = $clog2(NUM_TAPS);
  localparam int ACCW = COEF_BITS + 16 + 10;
  localparam int FRAC = COEF_BITS - 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TAPS - 1);

  state_e st_q, st_d;
  logic [AW-1:0] wr_q, rd_q, tap_q, clr_q;
  logic          clr_busy_q;
  logic [1:0]    phase_q, slot_q;
  logic          mode_q;
  logic signed [15:0] xin_q;
  logic [1:0]    sub_q;
  logic signed [15:0] mem [NUM_TAPS];
  logic signed [15:0] rdata_q;
  logic signed [15:0] out_q;
  logic          last_q, vout_q;
  logic          mac_clear, mac_load, mac_step, mac_done;
  logic signed [ACCW-1:0] acc;
  logic [1:0]    up, down;
  logic [AW-1:0] wr_next;
  logic [1:0]    phase_next;
  logic          more_out;
  logic signed [ACCW-1:0] scaled, q, r, qr;
  logic signed [ACCW-1:0] half;

  assign up   = mode_q ? UP_MODE1 : UP_MODE0;
  assign down = mode_q ? DOWN_MODE1 : DOWN_MODE0;
  assign wr_next = (wr_q == LAST_IDX) ? '0 : wr_q + AW'(1);
  assign phase_next = (phase_q + 2'd1 >= down) ? 2'd0 : phase_q + 2'd1;

  assign stall_o     = (st_q != ST_IDLE) || clr_busy_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Delay line RAM: one write port shared by clear and slot writes, and a registered read port.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_q] <= '0;
    end else if (st_q == ST_WRITE) begin
      mem[wr_q] <= (slot_q == 2'd0) ? xin_q : '0;
    end
    rdata_q <= mem[rd_q];
  end

  rfr_serial_mac #(.COEF_BITS(COEF_BITS), .ACC_BITS(ACCW)) u_mac (
    .clk_i, .rst_ni,
    .clear_i(mac_clear), .load_i(mac_load), .step_i(mac_step),
    .sample_i(rdata_q), .coef_i(coef_rom(8'(tap_q))),
    .done_o(mac_done), .acc_o(acc)
  );

  // Round half to even from the scaled sum, then saturate.
  always_comb begin
    scaled = (up == 2'd3) ? (acc + (acc <<< 1)) : (acc <<< 1);
    half   = ACCW'(1) <<< (FRAC - 1);
    q      = scaled >>> FRAC;
    r      = scaled - (q <<< FRAC);
    qr     = q;
    if (r > half || (r == half && q[0])) qr = q + ACCW'(1);
  end

  // sub_q: 0 = issue read, 1 = load MAC, 2 = step bits.
  always_comb begin
    st_d      = st_q;
    mac_clear = 1'b0;
    mac_load  = 1'b0;
    mac_step  = 1'b0;
    case (st_q)
      ST_IDLE:  if (valid_i && !clr_busy_q) st_d = ST_WRITE;
      ST_WRITE: begin
        // A slot without an output moves on to the next slot directly, or to idle after the last slot.
        if (phase_q == 2'd0) st_d = ST_MAC;
        else st_d = (slot_q + 2'd1 != up) ? ST_WRITE : ST_IDLE;
      end
      ST_MAC: begin
        mac_load = (sub_q == 2'd1);
        mac_step = (sub_q == 2'd2);
        if (mac_done && tap_q == LAST_IDX) st_d = ST_ROUND;
      end
      ST_ROUND: st_d = ST_OUT;
      ST_OUT:   if (!stall_i) st_d = more_out ? ST_WRITE : ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
    if (st_q == ST_WRITE) mac_clear = 1'b1;
  end

  assign more_out = (slot_q != up);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; wr_q <= '0; phase_q <= '0; slot_q <= '0;
      clr_q <= '0; clr_busy_q <= 1'b1; vout_q <= 1'b0;
      sub_q <= '0; tap_q <= '0; rd_q <= '0;
    end else begin
      st_q <= st_d;
      if (clr_busy_q) begin
        clr_q <= (clr_q == LAST_IDX) ? '0 : clr_q + AW'(1);
        if (clr_q == LAST_IDX) clr_busy_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: if (valid_i && !clr_busy_q) slot_q <= 2'd0;
        ST_WRITE: begin
          tap_q <= '0; sub_q <= 2'd0; rd_q <= wr_q;
          if (phase_q != 2'd0) begin
            wr_q <= wr_next; phase_q <= phase_next; slot_q <= slot_q + 2'd1;
          end
        end
        ST_MAC: begin
          case (sub_q)
            2'd0: sub_q <= 2'd1;
            2'd1: sub_q <= 2'd2;
            default: if (mac_done) begin
              sub_q <= 2'd0; tap_q <= tap_q + AW'(1);
              rd_q  <= (rd_q == '0) ? LAST_IDX : rd_q - AW'(1);
            end
          endcase
        end
        ST_ROUND: begin
          vout_q <= 1'b1;
          wr_q <= wr_next; phase_q <= phase_next; slot_q <= slot_q + 2'd1;
        end
        ST_OUT: if (!stall_i) vout_q <= 1'b0;
        default: ;
      endcase
    end
  end

  logic [1:0] rem_out;
  always_comb begin
    // Outputs still due in the remaining slots of this input.
    rem_out = 2'd0;
    if (3'(slot_q) + 3'd1 < 3'(up) && phase_next == 2'd0) rem_out = 2'd1;
    if (3'(slot_q) + 3'd2 < 3'(up) && down == 2'd2 && phase_next != 2'd0) rem_out = 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && valid_i && !clr_busy_q) xin_q <= sample_in_i;
    if (st_q == ST_ROUND) begin
      if (qr > ACCW'(32767))       out_q <= 16'sh7fff;
      else if (qr < -ACCW'(32768)) out_q <= -16'sh8000;
      else                         out_q <= qr[15:0];
      last_q <= (rem_out == 2'd0);
    end
  end

  assign valid_o      = vout_q;
  assign sample_out_o = out_q;
  assign last_o       = last_q;

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> st_q == ST_OUT) else $error("output valid outside delivery");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> stall_o) else $error("input accepted during clearing");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(sample_out_o)) else $error("result changed");
endmodule

// ===== test/rational_fir_resampler_tb.sv =====
// Self-checking testbench for rational_fir_resampler: directed table, then random
// samples in both rate modes, checked against a behavioral zero-stuffed FIR predictor.
// Depends on the RTL files (rfr_pkg, rfr_serial_mac, rational_fir_resampler) only.
module rational_fir_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS        = 63;
  localparam int FRAC        = 17;
  localparam int SETTLE_CYC  = 3000;
  localparam int HANG_LIMIT  = 20000;
  localparam bit MODE_UP3    = 1'b0;
  localparam bit MODE_DOWN3  = 1'b1;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } out_sample_t;

  typedef struct {
    logic signed [15:0] value;
    bit                 pinned;
    logic signed [15:0] pinned_out;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic signed [15:0] sample_in_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic signed [15:0] sample_out_o;
  logic               last_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_data_i = 1'b0;

  // Filter taps, Q1.17, summing to 2^17.
  const int fir_taps[TAPS] = '{
    -14, 81, 127, 75, -69, -213, -215, 0, 321, 473, 225, -351, -827, -695,
    150, 1165, 1445, 470, -1278, -2430, -1712, 845, 3514, 3865, 691, -4505,
    -7784, -5014, 5202, 19932, 32975, 38174, 32975, 19932, 5202, -5014,
    -7784, -4505, 691, 3865, 3514, 845, -1712, -2430, -1278, 470, 1445, 1165,
    150, -695, -827, -351, 225, 473, 321, 0, -215, -213, -69, 75, 127, 81, -14
  };

  // Full-scale steps, unit steps and alternating bit patterns for the directed rows.
  const logic signed [15:0] extreme_vals[11] = '{
    16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd1, -16'sd1,
    16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh7fff, 16'sh7fff
  };

  logic signed [15:0] history[TAPS];
  int                 slot_ptr;
  int                 decim_cnt;
  bit                 rate_sel;
  out_sample_t        pending_out[$];
  int                 mismatches = 0;
  bit                 idle_on = 1'b1;
  int                 quiet_cycles = 0;

  rational_fir_resampler i_dut (
    .clk_i, .rst_ni,
    .valid_i, .stall_o, .sample_in_i,
    .valid_o, .stall_i, .sample_out_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic signed [15:0] fir_sample(input int up);
    longint acc;
    longint q;
    longint r;
    int     idx;
    acc = 0;
    idx = slot_ptr;
    for (int k = 0; k < TAPS; k++) begin
      acc += longint'(fir_taps[k]) * longint'(history[idx]);
      idx = (idx == 0) ? TAPS - 1 : idx - 1;
    end
    acc *= up;
    q = acc >>> FRAC;
    r = acc - (q <<< FRAC);
    // Round half to even.
    if (r > (64'sd1 <<< (FRAC - 1)) || (r == (64'sd1 <<< (FRAC - 1)) && q[0])) q++;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic resample_step(input logic signed [15:0] x, input bit pinned,
                               input logic signed [15:0] pinned_out);
    int          up;
    int          down;
    out_sample_t outs[2];
    int          n;
    up = rate_sel ? 2 : 3;
    down = rate_sel ? 3 : 2;
    n = 0;
    for (int z = 0; z < up; z++) begin
      if (slot_ptr >= TAPS) slot_ptr = 0;
      history[slot_ptr] = (z == 0) ? x : 16'sd0;
      if (decim_cnt == 0) begin
        outs[n].value = pinned ? pinned_out : fir_sample(up);
        outs[n].last = 1'b0;
        n++;
      end
      slot_ptr = (slot_ptr + 1 >= TAPS) ? 0 : slot_ptr + 1;
      decim_cnt = (decim_cnt + 1 >= down) ? 0 : decim_cnt + 1;
    end
    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_out.push_back(outs[i]);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the caller must send again or drop valid.
  task automatic send_sample(input logic signed [15:0] x, input bit pinned = 1'b0,
                             input logic signed [15:0] pinned_out = '0);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (stall_o);
    resample_step(x, pinned, pinned_out);
    @(negedge clk_i);
  endtask

  task automatic drain_outputs();
    valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    // A sample with no output slot may still be in flight.
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_rate(input bit m);
    drain_outputs();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    rate_sel = m;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 255) - 128);
      default: return 16'($urandom());
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_sample_t exp_s;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("unexpected output %0d", sample_out_o));
      end else begin
        exp_s = pending_out.pop_front();
        if (sample_out_o !== exp_s.value)
          report_mismatch($sformatf("sample_out %0d, want %0d", sample_out_o, exp_s.value));
        if (last_o !== exp_s.last)
          report_mismatch($sformatf("last %0b, want %0b", last_o, exp_s.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output side back-pressure: a random stall before each transaction while idle_on is set.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = idle_on ? $urandom_range(0, 6) : 0;
      if (n > 0) begin
        stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    int        burst;
    logic signed [15:0] hold;
    for (int i = 0; i < TAPS; i++) history[i] = '0;
    slot_ptr = 0;
    decim_cnt = 0;
    rate_sel = MODE_UP3;

    // Silence right after reset gives silence out.
    for (int i = 0; i < 4; i++) rows.push_back(stim_row_t'{16'sd0, 1'b1, 16'sd0});
    foreach (extreme_vals[i]) begin
      r.value = extreme_vals[i];
      r.pinned = 1'b0;
      r.pinned_out = '0;
      rows.push_back(r);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_rate(MODE_UP3);
    foreach (rows[i]) send_sample(rows[i].value, rows[i].pinned, rows[i].pinned_out);
    write_rate(MODE_DOWN3);
    for (int i = 4; i < rows.size(); i++) send_sample(rows[i].value);

    for (int ph = 0; ph < 6; ph++) begin
      write_rate(ph[0] ? MODE_UP3 : MODE_DOWN3);
      idle_on = (ph != 3);
      for (int i = 0; i < 215; i++) begin
        if (ph == 2 && i == 100) begin
          valid_i <= 1'b0;
          while (pending_out.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
        // Occasional runs of a held full-scale value push the output into saturation.
        if ($urandom_range(0, 15) == 0) begin
          burst = $urandom_range(4, 24);
          hold = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          repeat (burst) send_sample(hold);
          i += burst;
        end else begin
          send_sample(rand_sample());
        end
      end
    end
    idle_on = 1'b1;

    drain_outputs();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== rational_fir_resampler.f =====
rtl/rfr_pkg.sv
rtl/rfr_serial_mac.sv
rtl/rational_fir_resampler.sv
test/rational_fir_resampler_tb.sv
